>>> hdl/bmfs_pkg.sv
// Shared types and constants of the bus master frame sender.
package bmfs_pkg;

    // Event codes carried by the cmd field; codes 10 to 15 carry no meaning.
    typedef enum logic [3:0] {
        CMD_QUERY     = 4'd0,
        CMD_DISCOVER  = 4'd1,
        CMD_PKT_BYTE  = 4'd2,
        CMD_TICK      = 4'd3,
        CMD_DISPATCH  = 4'd4,
        CMD_TX_READY  = 4'd5,
        CMD_TX_END    = 4'd6,
        CMD_EDGE      = 4'd7,
        CMD_TIMEOUT   = 4'd8,
        CMD_RX_BYTE   = 4'd9
    } t_cmd;

    // Bus phase of the half-duplex master.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_DATA   = 4'd2,
        PH_STOP   = 4'd3,
        PH_STOP2  = 4'd4,
        PH_DONE   = 4'd5,
        PH_WINDOW = 4'd6,
        PH_RECV   = 4'd7,
        PH_TXWAIT = 4'd8
    } t_phase;

    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_ENABLE  = 2'd1;
    localparam logic [1:0] EDGE_DISABLE = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_TX   = 2'd1;
    localparam logic [1:0] DIR_RX   = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_ESCAPE     = 3'd0;
    localparam logic [2:0] REG_DISCOVER   = 3'd1;
    localparam logic [2:0] REG_QUERY      = 3'd2;
    localparam logic [2:0] REG_PKT_START  = 3'd3;
    localparam logic [2:0] REG_PKT_STOP   = 3'd4;
    localparam logic [2:0] REG_INTERVAL   = 3'd5;
    localparam logic [2:0] REG_TIMEOUT    = 3'd6;

    // One result transaction.
    typedef struct packed {
        logic       status;
        logic       send_valid;
        logic [7:0] send_byte;
        logic [1:0] timer_action;
        logic [1:0] edge_action;
        logic [1:0] direction_action;
        logic       bus_idle;
    } t_result;

endpackage

>>> hdl/bmfs_ram.sv
// Generic single-port-write, registered-read RAM.
module bmfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bus_master_frame_sender_top.sv
// Top level of the bus master frame sender: request slots, framer and reply window.
//
// Every input transaction is accepted in any cycle in which the two-entry result
// register has room, and its result is registered there; while results are taken,
// a new event can follow every clock, else input stalls. The packet buffer is a
// RAM with a registered read; its read address follows the next send position, so
// the byte to transmit is already waiting when the transmitter asks for it. The
// buffer needs no clearing after reset, since a frame only reads bytes that were
// loaded. Loads are refused while a packet is pending and once PACKET_DEPTH bytes
// have been loaded without a final byte.
module bus_master_frame_sender_top #(
    parameter int PACKET_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Event channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_node_address,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_final_byte,
    input  logic        i_line_valid,
    input  logic        i_reply_complete,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic [1:0]  o_timer_action,
    output logic [1:0]  o_edge_action,
    output logic [1:0]  o_direction_action,
    output logic        o_bus_idle
);
    import bmfs_pkg::*;

    localparam int AW = $clog2(PACKET_DEPTH);
    localparam int CW = $clog2(PACKET_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PACKET_DEPTH);

    // Configuration registers
    logic [7:0]  r_escape_code;
    logic [7:0]  r_discover_code;
    logic [7:0]  r_query_code;
    logic [7:0]  r_pkt_start_code;
    logic [7:0]  r_pkt_stop_code;
    logic [15:0] r_discover_interval;
    logic [7:0]  r_reply_timeout;

    // Block state
    t_phase        r_phase, n_phase;
    logic          r_query_pending, n_query_pending;
    logic [7:0]    r_query_target, n_query_target;
    logic          r_discover_pending, n_discover_pending;
    logic          r_packet_pending, n_packet_pending;
    logic [CW-1:0] r_packet_length, n_packet_length;
    logic [CW-1:0] r_load_count, n_load_count;
    logic [7:0]    r_frame_start, n_frame_start;
    logic          r_frame_has_stop, n_frame_has_stop;
    logic          r_frame_from_packet, n_frame_from_packet;
    logic [CW-1:0] r_frame_length, n_frame_length;
    logic [7:0]    r_frame_query_byte, n_frame_query_byte;
    logic [CW-1:0] r_send_position, n_send_position;
    logic          r_escape_sent, n_escape_sent;
    logic [15:0]   r_tick_count, n_tick_count;

    // Result register and skid entry
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    t_result w_res;

    logic          w_accept;
    logic          w_out_take;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_raddr;
    logic [7:0]    w_ram_rdata;
    logic [7:0]    w_data_byte;
    logic [CW-1:0] w_pos_inc;
    logic [CW-1:0] w_load_inc;

    assign pready     = 1'b1;
    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_code       <= 8'd92;
            r_discover_code     <= 8'd1;
            r_query_code        <= 8'd2;
            r_pkt_start_code    <= 8'd3;
            r_pkt_stop_code     <= 8'd4;
            r_discover_interval <= 16'd500;
            r_reply_timeout     <= 8'd20;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_ESCAPE:    r_escape_code       <= pwdata[7:0];
                REG_DISCOVER:  r_discover_code     <= pwdata[7:0];
                REG_QUERY:     r_query_code        <= pwdata[7:0];
                REG_PKT_START: r_pkt_start_code    <= pwdata[7:0];
                REG_PKT_STOP:  r_pkt_stop_code     <= pwdata[7:0];
                REG_INTERVAL:  r_discover_interval <= pwdata[15:0];
                REG_TIMEOUT:   r_reply_timeout     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ESCAPE:    prdata = {24'd0, r_escape_code};
            REG_DISCOVER:  prdata = {24'd0, r_discover_code};
            REG_QUERY:     prdata = {24'd0, r_query_code};
            REG_PKT_START: prdata = {24'd0, r_pkt_start_code};
            REG_PKT_STOP:  prdata = {24'd0, r_pkt_stop_code};
            REG_INTERVAL:  prdata = {16'd0, r_discover_interval};
            REG_TIMEOUT:   prdata = {24'd0, r_reply_timeout};
            default:       prdata = 32'd0;
        endcase
    end

    // The read address tracks the next send position, so the RAM output always
    // holds the buffer byte at the current send position.
    assign w_ram_raddr = (n_send_position < DEPTH_C) ? n_send_position[AW-1:0] : '0;

    bmfs_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_DEPTH)
    ) u_packet_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_load_count[AW-1:0]),
        .i_wdata (i_payload_byte),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_data_byte = r_frame_from_packet ? w_ram_rdata : r_frame_query_byte;
    assign w_pos_inc   = r_send_position + CW'(1);
    assign w_load_inc  = r_load_count + CW'(1);

    always_comb begin
        n_phase             = r_phase;
        n_query_pending     = r_query_pending;
        n_query_target      = r_query_target;
        n_discover_pending  = r_discover_pending;
        n_packet_pending    = r_packet_pending;
        n_packet_length     = r_packet_length;
        n_load_count        = r_load_count;
        n_frame_start       = r_frame_start;
        n_frame_has_stop    = r_frame_has_stop;
        n_frame_from_packet = r_frame_from_packet;
        n_frame_length      = r_frame_length;
        n_frame_query_byte  = r_frame_query_byte;
        n_send_position     = r_send_position;
        n_escape_sent       = r_escape_sent;
        n_tick_count        = r_tick_count;
        w_ram_we            = 1'b0;
        w_res               = '0;

        if (w_accept) begin
            case (t_cmd'(i_cmd))
                CMD_QUERY: begin
                    if (r_query_pending) begin
                        w_res.status = 1'b1;
                    end else begin
                        n_query_target  = i_node_address;
                        n_query_pending = 1'b1;
                    end
                end
                CMD_DISCOVER: begin
                    if (r_discover_pending) begin
                        w_res.status = 1'b1;
                    end else begin
                        n_discover_pending = 1'b1;
                    end
                end
                CMD_PKT_BYTE: begin
                    if (r_packet_pending || r_load_count >= DEPTH_C) begin
                        w_res.status = 1'b1;
                    end else begin
                        w_ram_we     = 1'b1;
                        n_load_count = w_load_inc;
                        if (i_final_byte) begin
                            n_packet_length  = w_load_inc;
                            n_packet_pending = 1'b1;
                            n_load_count     = '0;
                        end
                    end
                end
                CMD_TICK: begin
                    n_tick_count = r_tick_count + 16'd1;
                    if (n_tick_count == r_discover_interval) begin
                        n_tick_count       = '0;
                        n_discover_pending = 1'b1;
                    end
                end
                CMD_DISPATCH: begin
                    if (r_phase == PH_IDLE &&
                        (r_discover_pending || r_query_pending || r_packet_pending)) begin
                        n_phase                = PH_START;
                        w_res.send_valid       = 1'b1;
                        w_res.send_byte        = r_escape_code;
                        w_res.direction_action = DIR_TX;
                        if (r_discover_pending) begin
                            n_frame_start       = r_discover_code;
                            n_frame_length      = '0;
                            n_frame_has_stop    = 1'b0;
                            n_frame_from_packet = 1'b0;
                            n_discover_pending  = 1'b0;
                        end else if (r_query_pending) begin
                            n_frame_query_byte  = r_query_target;
                            n_frame_start       = r_query_code;
                            n_frame_length      = CW'(1);
                            n_frame_has_stop    = 1'b0;
                            n_frame_from_packet = 1'b0;
                            n_query_pending     = 1'b0;
                        end else begin
                            n_frame_start       = r_pkt_start_code;
                            n_frame_length      = r_packet_length;
                            n_frame_has_stop    = 1'b1;
                            n_frame_from_packet = 1'b1;
                        end
                    end
                end
                CMD_TX_READY: begin
                    case (r_phase)
                        PH_START: begin
                            w_res.send_valid = 1'b1;
                            w_res.send_byte  = r_frame_start;
                            n_send_position  = '0;
                            if (r_frame_length != '0) begin
                                n_phase = PH_DATA;
                            end else if (r_frame_has_stop) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_phase = PH_TXWAIT;
                            end
                        end
                        PH_DATA: begin
                            w_res.send_valid = 1'b1;
                            if (w_data_byte == r_escape_code && !r_escape_sent) begin
                                // First copy of a doubled escape byte.
                                w_res.send_byte = r_escape_code;
                                n_escape_sent   = 1'b1;
                            end else begin
                                w_res.send_byte = w_data_byte;
                                n_escape_sent   = 1'b0;
                                n_send_position = w_pos_inc;
                                if (w_pos_inc >= r_frame_length) begin
                                    if (!r_frame_has_stop) begin
                                        n_phase = PH_TXWAIT;
                                    end else begin
                                        n_packet_pending = 1'b0;
                                        n_phase          = PH_STOP;
                                    end
                                end
                            end
                        end
                        PH_STOP: begin
                            w_res.send_valid = 1'b1;
                            w_res.send_byte  = r_escape_code;
                            n_phase          = PH_STOP2;
                        end
                        PH_STOP2: begin
                            w_res.send_valid = 1'b1;
                            w_res.send_byte  = r_pkt_stop_code;
                            n_phase          = PH_DONE;
                        end
                        default: ;
                    endcase
                end
                CMD_TX_END: begin
                    if (r_phase == PH_TXWAIT) begin
                        w_res.timer_action = TMR_START;
                        w_res.edge_action  = EDGE_ENABLE;
                        n_phase            = PH_WINDOW;
                    end else if (r_phase == PH_DONE) begin
                        n_phase = PH_IDLE;
                    end
                    if (n_phase == PH_IDLE || n_phase == PH_WINDOW) begin
                        w_res.direction_action = DIR_RX;
                    end
                end
                CMD_EDGE: begin
                    if (r_phase == PH_WINDOW) begin
                        if (i_line_valid) begin
                            n_phase            = PH_RECV;
                            w_res.edge_action  = EDGE_DISABLE;
                            w_res.timer_action = TMR_START;
                        end
                    end else begin
                        w_res.edge_action = EDGE_DISABLE;
                    end
                end
                CMD_TIMEOUT: begin
                    if (r_phase == PH_WINDOW || r_phase == PH_RECV) begin
                        n_phase = PH_IDLE;
                    end
                    w_res.edge_action  = EDGE_DISABLE;
                    w_res.timer_action = TMR_STOP;
                end
                CMD_RX_BYTE: begin
                    w_res.timer_action = TMR_START;
                    if (i_reply_complete) begin
                        w_res.timer_action = TMR_STOP;
                        n_phase            = PH_IDLE;
                    end
                end
                default: ;
            endcase
            w_res.bus_idle = (n_phase == PH_IDLE);
        end
    end

    // Result register with one skid entry behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_out_take) begin
            n_out_valid = r_skid_valid;
            n_out       = r_skid;
            n_skid_valid = 1'b0;
        end
        if (w_accept) begin
            if (!r_out_valid || w_out_take) begin
                n_out_valid = 1'b1;
                n_out       = w_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= PH_IDLE;
            r_query_pending     <= 1'b0;
            r_query_target      <= '0;
            r_discover_pending  <= 1'b0;
            r_packet_pending    <= 1'b0;
            r_packet_length     <= '0;
            r_load_count        <= '0;
            r_frame_start       <= '0;
            r_frame_has_stop    <= 1'b0;
            r_frame_from_packet <= 1'b0;
            r_frame_length      <= '0;
            r_frame_query_byte  <= '0;
            r_send_position     <= '0;
            r_escape_sent       <= 1'b0;
            r_tick_count        <= '0;
            r_out_valid         <= 1'b0;
            r_skid_valid        <= 1'b0;
        end else begin
            r_phase             <= n_phase;
            r_query_pending     <= n_query_pending;
            r_query_target      <= n_query_target;
            r_discover_pending  <= n_discover_pending;
            r_packet_pending    <= n_packet_pending;
            r_packet_length     <= n_packet_length;
            r_load_count        <= n_load_count;
            r_frame_start       <= n_frame_start;
            r_frame_has_stop    <= n_frame_has_stop;
            r_frame_from_packet <= n_frame_from_packet;
            r_frame_length      <= n_frame_length;
            r_frame_query_byte  <= n_frame_query_byte;
            r_send_position     <= n_send_position;
            r_escape_sent       <= n_escape_sent;
            r_tick_count        <= n_tick_count;
            r_out_valid         <= n_out_valid;
            r_skid_valid        <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_send_valid       = r_out.send_valid;
    assign o_send_byte        = r_out.send_byte;
    assign o_timer_action     = r_out.timer_action;
    assign o_edge_action      = r_out.edge_action;
    assign o_direction_action = r_out.direction_action;
    assign o_bus_idle         = r_out.bus_idle;

`ifndef SYNTHESIS
    // The skid entry is only filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // Only request and load transactions may be refused.
    a_status_only_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd != CMD_QUERY && i_cmd != CMD_DISCOVER &&
         i_cmd != CMD_PKT_BYTE) |-> !w_res.status)
        else $error("refusal reported for an event that cannot be refused");

    // The buffer must stay locked while its bytes are still being sent.
    a_packet_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA && r_frame_from_packet) |-> r_packet_pending)
        else $error("packet released before its last data byte was sent");

    // While sending data, the position stays inside the frame.
    a_position_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_send_position < r_frame_length))
        else $error("send position ran past the frame length");

    // The load counter never passes the buffer depth.
    a_load_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= DEPTH_C)
        else $error("load count exceeds the packet buffer depth");
`endif

endmodule

>>> verif/tb_bus_master_frame_sender_top.sv
// Self-checking testbench for the bus master frame sender top level.
`timescale 1ns / 100ps

module tb_bus_master_frame_sender_top;
    import bmfs_pkg::*;

    localparam int BUF_DEPTH         = 256;
    localparam int N_DIRECTED        = 26;
    localparam int N_SETTINGS        = 5;
    localparam int ITEMS_PER_SETTING = 65;
    localparam int CYCLE_LIMIT       = 500000;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] node_address;
        logic [7:0] payload_byte;
        logic       final_byte;
        logic       line_valid;
        logic       reply_complete;
    } t_bus_event;

    typedef struct packed {
        t_bus_event ev;
        logic       typed;
        t_result    want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [4:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic [3:0]  i_cmd            = '0;
    logic [7:0]  i_node_address   = '0;
    logic [7:0]  i_payload_byte   = '0;
    logic        i_final_byte     = 1'b0;
    logic        i_line_valid     = 1'b0;
    logic        i_reply_complete = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic        o_status;
    logic        o_send_valid;
    logic [7:0]  o_send_byte;
    logic [1:0]  o_timer_action;
    logic [1:0]  o_edge_action;
    logic [1:0]  o_direction_action;
    logic        o_bus_idle;

    bus_master_frame_sender_top #(
        .PACKET_DEPTH(BUF_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_node_address     (i_node_address),
        .i_payload_byte     (i_payload_byte),
        .i_final_byte       (i_final_byte),
        .i_line_valid       (i_line_valid),
        .i_reply_complete   (i_reply_complete),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_send_valid       (o_send_valid),
        .o_send_byte        (o_send_byte),
        .o_timer_action     (o_timer_action),
        .o_edge_action      (o_edge_action),
        .o_direction_action (o_direction_action),
        .o_bus_idle         (o_bus_idle)
    );

    // Shadow copy of the configuration registers.
    logic [7:0]  cfg_escape    = 8'd92;
    logic [7:0]  cfg_discover  = 8'd1;
    logic [7:0]  cfg_query     = 8'd2;
    logic [7:0]  cfg_pkt_start = 8'd3;
    logic [7:0]  cfg_pkt_stop  = 8'd4;
    logic [15:0] cfg_interval  = 16'd500;
    logic [7:0]  cfg_timeout   = 8'd20;

    // Shadow copy of the block state.
    t_phase      st_phase      = PH_IDLE;
    logic        pend_query    = 1'b0;
    logic        pend_discover = 1'b0;
    logic        pend_packet   = 1'b0;
    logic [7:0]  query_addr    = '0;
    logic [8:0]  pkt_len       = '0;
    logic [8:0]  load_cnt      = '0;
    logic [7:0]  pkt_mem [BUF_DEPTH];
    logic [7:0]  fr_start      = '0;
    logic        fr_stop       = 1'b0;
    logic        fr_pkt        = 1'b0;
    logic [8:0]  fr_len        = '0;
    logic [7:0]  fr_qbyte      = '0;
    logic [8:0]  tx_pos        = '0;
    logic        esc_done      = 1'b0;
    logic [15:0] ticks         = '0;

    t_result     awaited_results [$];
    t_stim_row   directed [N_DIRECTED];
    int          n_faults   = 0;
    int          n_checked  = 0;
    int          n_events   = 0;
    int          n_frames   = 0;
    bit          hold_done  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_fault(input string msg);
        n_faults++;
        if (n_faults <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic string fmt_result(input t_result r);
        return $sformatf("status=%0d send=%0d byte=%02h timer=%0d edge=%0d dir=%0d idle=%0d",
                         r.status, r.send_valid, r.send_byte, r.timer_action,
                         r.edge_action, r.direction_action, r.bus_idle);
    endfunction

    function automatic void open_frame(input logic [7:0] code, input logic [8:0] len,
                                       input logic with_stop, input logic from_buf);
        st_phase = PH_START;
        fr_start = code;
        fr_len   = len;
        fr_stop  = with_stop;
        fr_pkt   = from_buf;
    endfunction

    // Advances the shadow state by one event and returns the result it must produce.
    function automatic t_result bus_outputs(input t_bus_event ev);
        t_result    r;
        logic [7:0] b;
        r = '0;
        case (ev.cmd)
            CMD_QUERY: begin
                if (pend_query) begin
                    r.status = 1'b1;
                end else begin
                    query_addr = ev.node_address;
                    pend_query = 1'b1;
                end
            end
            CMD_DISCOVER: begin
                if (pend_discover) begin
                    r.status = 1'b1;
                end else begin
                    pend_discover = 1'b1;
                end
            end
            CMD_PKT_BYTE: begin
                if (pend_packet || load_cnt >= BUF_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    pkt_mem[load_cnt[7:0]] = ev.payload_byte;
                    load_cnt = load_cnt + 9'd1;
                    if (ev.final_byte) begin
                        pkt_len     = load_cnt;
                        pend_packet = 1'b1;
                        load_cnt    = '0;
                    end
                end
            end
            CMD_TICK: begin
                ticks = ticks + 16'd1;
                if (ticks == cfg_interval) begin
                    ticks         = '0;
                    pend_discover = 1'b1;
                end
            end
            CMD_DISPATCH: begin
                if (st_phase == PH_IDLE) begin
                    if (pend_discover) begin
                        open_frame(cfg_discover, 9'd0, 1'b0, 1'b0);
                        pend_discover = 1'b0;
                    end else if (pend_query) begin
                        fr_qbyte = query_addr;
                        open_frame(cfg_query, 9'd1, 1'b0, 1'b0);
                        pend_query = 1'b0;
                    end else if (pend_packet) begin
                        open_frame(cfg_pkt_start, pkt_len, 1'b1, 1'b1);
                    end
                    if (st_phase == PH_START) begin
                        r.send_valid       = 1'b1;
                        r.send_byte        = cfg_escape;
                        r.direction_action = DIR_TX;
                    end
                end
            end
            CMD_TX_READY: begin
                case (st_phase)
                    PH_START: begin
                        r.send_valid = 1'b1;
                        r.send_byte  = fr_start;
                        tx_pos       = '0;
                        if (fr_len != 0) begin
                            st_phase = PH_DATA;
                        end else if (fr_stop) begin
                            st_phase = PH_STOP;
                        end else begin
                            st_phase = PH_TXWAIT;
                        end
                    end
                    PH_DATA: begin
                        b = fr_pkt ? pkt_mem[tx_pos[7:0]] : fr_qbyte;
                        r.send_valid = 1'b1;
                        // An escape-valued byte goes out twice: first copy, then the byte.
                        if (b == cfg_escape && !esc_done) begin
                            r.send_byte = cfg_escape;
                            esc_done    = 1'b1;
                        end else begin
                            esc_done    = 1'b0;
                            r.send_byte = b;
                            tx_pos      = tx_pos + 9'd1;
                            if (tx_pos >= fr_len) begin
                                if (!fr_stop) begin
                                    st_phase = PH_TXWAIT;
                                end else begin
                                    pend_packet = 1'b0;
                                    st_phase    = PH_STOP;
                                end
                            end
                        end
                    end
                    PH_STOP: begin
                        r.send_valid = 1'b1;
                        r.send_byte  = cfg_escape;
                        st_phase     = PH_STOP2;
                    end
                    PH_STOP2: begin
                        r.send_valid = 1'b1;
                        r.send_byte  = cfg_pkt_stop;
                        st_phase     = PH_DONE;
                    end
                    default: ;
                endcase
            end
            CMD_TX_END: begin
                if (st_phase == PH_TXWAIT) begin
                    r.timer_action = TMR_START;
                    r.edge_action  = EDGE_ENABLE;
                    st_phase       = PH_WINDOW;
                end
                if (st_phase == PH_DONE) begin
                    st_phase = PH_IDLE;
                end
                if (st_phase == PH_IDLE || st_phase == PH_WINDOW) begin
                    r.direction_action = DIR_RX;
                end
            end
            CMD_EDGE: begin
                if (st_phase == PH_WINDOW) begin
                    if (ev.line_valid) begin
                        st_phase       = PH_RECV;
                        r.edge_action  = EDGE_DISABLE;
                        r.timer_action = TMR_START;
                    end
                end else begin
                    r.edge_action = EDGE_DISABLE;
                end
            end
            CMD_TIMEOUT: begin
                if (st_phase == PH_WINDOW || st_phase == PH_RECV) begin
                    st_phase = PH_IDLE;
                end
                r.edge_action  = EDGE_DISABLE;
                r.timer_action = TMR_STOP;
            end
            CMD_RX_BYTE: begin
                r.timer_action = TMR_START;
                if (ev.reply_complete) begin
                    r.timer_action = TMR_STOP;
                    st_phase       = PH_IDLE;
                end
            end
            default: ;
        endcase
        r.bus_idle = (st_phase == PH_IDLE);
        return r;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_ESCAPE:    cfg_escape    = val[7:0];
            REG_DISCOVER:  cfg_discover  = val[7:0];
            REG_QUERY:     cfg_query     = val[7:0];
            REG_PKT_START: cfg_pkt_start = val[7:0];
            REG_PKT_STOP:  cfg_pkt_stop  = val[7:0];
            REG_INTERVAL:  cfg_interval  = val[15:0];
            REG_TIMEOUT:   cfg_timeout   = val[7:0];
            default: ;
        endcase
    endfunction

    function automatic t_result outcome(input logic st, input logic sv, input logic [7:0] sb,
                                        input logic [1:0] tmr, input logic [1:0] edg,
                                        input logic [1:0] dir, input logic idle);
        t_result r;
        r = {st, sv, sb, tmr, edg, dir, idle};
        return r;
    endfunction

    function automatic t_stim_row mk_row(input logic [3:0] cmd, input logic [7:0] addr,
                                         input logic [7:0] pbyte, input logic fin,
                                         input logic lval, input logic rdone,
                                         input logic typed, input t_result want);
        t_stim_row row;
        row.ev    = {cmd, addr, pbyte, fin, lval, rdone};
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Byte values lean toward the escape code so that doubling shows up often.
    function automatic logic [7:0] some_byte();
        return ($urandom_range(0, 3) == 0) ? cfg_escape : 8'($urandom);
    endfunction

    function automatic logic [3:0] request_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return CMD_QUERY;
        if (r < 25) return CMD_DISCOVER;
        if (r < 70) return CMD_PKT_BYTE;
        if (r < 95) return CMD_TICK;
        return CMD_DISPATCH;
    endfunction

    // Picks an event that mostly moves the current frame along, with some noise mixed in.
    function automatic t_bus_event pick_event();
        t_bus_event  ev;
        int unsigned r;
        ev.node_address   = some_byte();
        ev.payload_byte   = some_byte();
        ev.final_byte     = ($urandom_range(0, 3) == 0);
        ev.line_valid     = 1'($urandom_range(0, 1));
        ev.reply_complete = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            ev.cmd = 4'($urandom_range(0, 15));
        end else begin
            case (st_phase)
                PH_START, PH_DATA, PH_STOP, PH_STOP2:
                    ev.cmd = (r < 75) ? CMD_TX_READY : (r < 80) ? CMD_RX_BYTE : request_cmd();
                PH_TXWAIT, PH_DONE:
                    ev.cmd = (r < 60) ? CMD_TX_END : (r < 65) ? CMD_TX_READY : request_cmd();
                PH_WINDOW:
                    ev.cmd = (r < 40) ? CMD_EDGE : (r < 55) ? CMD_TIMEOUT :
                             (r < 70) ? CMD_RX_BYTE : request_cmd();
                PH_RECV:
                    ev.cmd = (r < 55) ? CMD_RX_BYTE : (r < 65) ? CMD_TIMEOUT :
                             (r < 70) ? CMD_EDGE : request_cmd();
                default:
                    ev.cmd = (r < 40 && (pend_discover || pend_query || pend_packet)) ?
                             CMD_DISPATCH : request_cmd();
            endcase
        end
        return ev;
    endfunction

    // Offers one event and records its prediction once the transaction is accepted.
    task automatic drive_event(input t_bus_event ev, input logic typed, input t_result want);
        int      gap;
        t_result predicted;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= ev.cmd;
        i_node_address   <= ev.node_address;
        i_payload_byte   <= ev.payload_byte;
        i_final_byte     <= ev.final_byte;
        i_line_valid     <= ev.line_valid;
        i_reply_complete <= ev.reply_complete;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted = bus_outputs(ev);
        awaited_results.push_back(typed ? want : predicted);
        n_events++;
        if (ev.cmd == CMD_DISPATCH && predicted.send_valid) begin
            n_frames++;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (idx == REG_INTERVAL) ? 32'h0000_FFFF : 32'h0000_00FF;
        reg_access(1'b1, idx, val, rd);
        apply_reg(idx, val);
        reg_access(1'b0, idx, 32'd0, rd);
        if ((rd & mask) !== (val & mask)) begin
            report_fault($sformatf("Register %0d read back %08h, wrote %08h", idx, rd, val));
        end
    endtask

    // Setting 0 holds the low extremes, setting 1 the high ones, the rest are random.
    task automatic load_settings(input int which);
        logic [7:0]  esc, dcode, qcode, pstart, pstop, tmo;
        logic [15:0] ivl;
        case (which)
            0: begin
                esc = 8'd0; dcode = 8'd0; qcode = 8'd0; pstart = 8'd0; pstop = 8'd1;
                ivl = 16'd1; tmo = 8'd1;
            end
            1: begin
                esc = 8'hFF; dcode = 8'hFF; qcode = 8'hFF; pstart = 8'hFF; pstop = 8'hFF;
                ivl = 16'hFFFF; tmo = 8'hFF;
            end
            default: begin
                esc    = 8'($urandom);
                dcode  = 8'($urandom);
                qcode  = 8'($urandom);
                pstart = 8'($urandom);
                // A zero stop code must still close packet frames.
                pstop  = (which == 2) ? 8'd0 : 8'($urandom_range(1, 255));
                ivl    = 16'($urandom_range(2, 40));
                tmo    = 8'($urandom_range(1, 255));
            end
        endcase
        program_reg(REG_ESCAPE, {24'd0, esc});
        program_reg(REG_DISCOVER, {24'd0, dcode});
        program_reg(REG_QUERY, {24'd0, qcode});
        program_reg(REG_PKT_START, {24'd0, pstart});
        program_reg(REG_PKT_STOP, {24'd0, pstop});
        program_reg(REG_INTERVAL, {16'd0, ivl});
        program_reg(REG_TIMEOUT, {24'd0, tmo});
    endtask

    // Walks the bus back to idle and serves every pending request.
    task automatic flush_bus();
        t_bus_event ev;
        while (st_phase != PH_IDLE || pend_discover || pend_query || pend_packet) begin
            ev = pick_event();
            ev.reply_complete = 1'b1;
            case (st_phase)
                PH_START, PH_DATA, PH_STOP, PH_STOP2: ev.cmd = CMD_TX_READY;
                PH_TXWAIT, PH_DONE:                   ev.cmd = CMD_TX_END;
                PH_WINDOW, PH_RECV:                   ev.cmd = CMD_RX_BYTE;
                default:                              ev.cmd = CMD_DISPATCH;
            endcase
            drive_event(ev, 1'b0, '0);
        end
    endtask

    task automatic load_bytes(input int count, input logic fin_last);
        t_bus_event ev;
        for (int k = 0; k < count; k++) begin
            ev = pick_event();
            ev.cmd        = CMD_PKT_BYTE;
            ev.final_byte = fin_last && (k == count - 1);
            drive_event(ev, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, one long hold-off, and the in-order comparison.
    initial begin : result_checker
        int      stall;
        bit      fast;
        t_result got;
        t_result want;
        fast = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                fast = !fast;
            end
            stall = fast ? 0 : $urandom_range(0, 10);
            if (!hold_done && n_checked >= 400) begin
                // Long hold-off so that the result buffer fills and the input side stalls.
                stall     = stall + 150;
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            got = {o_status, o_send_valid, o_send_byte, o_timer_action, o_edge_action,
                   o_direction_action, o_bus_idle};
            if (awaited_results.size() == 0) begin
                report_fault($sformatf("Unexpected result transaction: %s", fmt_result(got)));
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    report_fault($sformatf("Result %0d mismatch\n  got      %s\n  expected %s",
                                           n_checked, fmt_result(got), fmt_result(want)));
                end
            end
            n_checked++;
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 cycles, awaited_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_bus_event ev;
        int         counted;
        int         n_tail;
        // Directed rows: idle-bus corner cases, full request slots, busy packet slot,
        // then one discover and one query frame with an escape-valued address.
        directed[0]  = mk_row(CMD_TX_READY, 8'hFF, 8'hFF, 1, 1, 1, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[1]  = mk_row(CMD_DISPATCH, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[2]  = mk_row(CMD_EDGE, 8'd0, 8'd0, 0, 1, 0, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_DISABLE, DIR_NONE, 1));
        directed[3]  = mk_row(CMD_TIMEOUT, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_STOP, EDGE_DISABLE, DIR_NONE, 1));
        directed[4]  = mk_row(CMD_RX_BYTE, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_START, EDGE_NONE, DIR_NONE, 1));
        directed[5]  = mk_row(CMD_TX_END, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_RX, 1));
        directed[6]  = mk_row(4'hF, 8'hFF, 8'hFF, 1, 1, 1, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[7]  = mk_row(CMD_DISCOVER, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[8]  = mk_row(CMD_DISCOVER, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(1, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[9]  = mk_row(CMD_QUERY, 8'd92, 8'd0, 0, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[10] = mk_row(CMD_QUERY, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(1, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[11] = mk_row(CMD_PKT_BYTE, 8'd0, 8'd92, 0, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[12] = mk_row(CMD_PKT_BYTE, 8'd0, 8'hFF, 1, 0, 0, 1,
                              outcome(0, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[13] = mk_row(CMD_PKT_BYTE, 8'd0, 8'h00, 1, 0, 0, 1,
                              outcome(1, 0, 8'd0, TMR_NONE, EDGE_NONE, DIR_NONE, 1));
        directed[14] = mk_row(CMD_DISPATCH, 8'd0, 8'd0, 0, 0, 0, 1,
                              outcome(0, 1, 8'd92, TMR_NONE, EDGE_NONE, DIR_TX, 0));
        directed[15] = mk_row(CMD_TX_READY, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[16] = mk_row(CMD_TX_END, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[17] = mk_row(CMD_EDGE, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[18] = mk_row(CMD_EDGE, 8'd0, 8'd0, 0, 1, 0, 0, '0);
        directed[19] = mk_row(CMD_RX_BYTE, 8'd0, 8'd0, 0, 0, 1, 0, '0);
        directed[20] = mk_row(CMD_DISPATCH, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[21] = mk_row(CMD_TX_READY, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[22] = mk_row(CMD_TX_READY, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[23] = mk_row(CMD_TX_READY, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[24] = mk_row(CMD_TX_END, 8'd0, 8'd0, 0, 0, 0, 0, '0);
        directed[25] = mk_row(CMD_TIMEOUT, 8'd0, 8'd0, 0, 0, 0, 0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            drive_event(directed[i].ev, directed[i].typed, directed[i].want);
        end

        for (int s = 0; s < N_SETTINGS; s++) begin
            wait_drained();
            load_settings(s);
            counted = 0;
            while (counted < ITEMS_PER_SETTING) begin
                ev = pick_event();
                drive_event(ev, 1'b0, '0);
                if (ev.cmd <= CMD_RX_BYTE) begin
                    counted++;
                end
            end
        end

        // A packet of full buffer depth, then loads past the depth. The second part
        // leaves the packet slot unusable, so it comes last.
        flush_bus();
        load_bytes(BUF_DEPTH - int'(load_cnt), 1'b1);
        flush_bus();
        load_bytes(BUF_DEPTH + 3, 1'b0);
        n_tail = 0;
        while (n_tail < 30) begin
            ev = pick_event();
            drive_event(ev, 1'b0, '0);
            n_tail++;
        end

        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Drove %0d events (%0d directed) over %0d register settings; %0d frames opened,",
                 n_events, N_DIRECTED, N_SETTINGS + 1, n_frames);
        $display("%0d results checked, including a long output stall and a full-depth packet.",
                 n_checked);
        if (n_faults == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/bmfs_pkg.sv
hdl/bmfs_ram.sv
hdl/bus_master_frame_sender_top.sv
verif/tb_bus_master_frame_sender_top.sv
